>>> sv/ale_pkg.sv
// Package for the array list engine: sizes, codes, cell control and helpers.
`default_nettype none
package ale_pkg;

  // List size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the channels
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_POS  = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_LOCATE   = 3'd2,
    KIND_INS_SORT = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic [IDX_W-1:0]           tgt;
    logic signed [VALUE_W-1:0]  value;
    logic                       cmp_en;
  } cell_ctrl_t;

  // Lowest set bit: MSB of the result is set when no bit is set
  function automatic logic [IDX_W:0] first_set(input logic [CAPACITY-1:0] v);
    logic [IDX_W:0] res;
    res = {1'b1, {IDX_W{1'b0}}};
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b0, IDX_W'(i)};
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/ale_in_if.sv
// Input and result channel interfaces of the array list engine.
`default_nettype none
interface ale_in_if;
  logic                               valid;
  logic                               ready;
  logic [ale_pkg::KIND_W-1:0]         kind;
  logic signed [ale_pkg::VALUE_W-1:0] value;
  logic [ale_pkg::POS_W-1:0]          position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface ale_out_if;
  logic                         valid;
  logic                         ready;
  logic [ale_pkg::STATUS_W-1:0] status;
  logic [ale_pkg::INDEX_W-1:0]  index;
  logic [ale_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output index, output count, input ready);
  modport sink   (input valid, input status, input index, input count, output ready);
endinterface
`default_nettype wire

>>> sv/ale_cell.sv
// One list cell: holds an entry, compares it with the item value, shifts.
`default_nettype none
module ale_cell (
  input  wire logic                              clk,
  input  wire ale_pkg::cell_ctrl_t               ctrl,
  input  wire logic [ale_pkg::IDX_W-1:0]         cell_idx,
  input  wire logic signed [ale_pkg::VALUE_W-1:0] left_data,
  input  wire logic signed [ale_pkg::VALUE_W-1:0] right_data,
  output logic signed [ale_pkg::VALUE_W-1:0]     data_r,
  output logic                                   eq_r,
  output logic                                   lt_r
);
  import ale_pkg::*;

  logic signed [VALUE_W-1:0] data_nxt;

  // Entry update: open a slot at the target or close the gap there
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_SHIFT_UP: begin
        if (cell_idx > ctrl.tgt) begin
          data_nxt = left_data;
        end else if (cell_idx == ctrl.tgt) begin
          data_nxt = ctrl.value;
        end
      end
      OP_SHIFT_DOWN: begin
        if (cell_idx >= ctrl.tgt) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Local compare flags, registered for the apply cycle
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      eq_r <= (data_r == ctrl.value);
      lt_r <= (data_r < ctrl.value);
    end
  end

endmodule
`default_nettype wire

>>> sv/array_list_engine.sv
// Array list engine top level: control sequencer over a row of list cells.
// After an input transfer the item passes the compare state, then the apply state.
// One item in work at a time (input ready only while idle): capture, compare of the
// cell row, and apply, which shifts the row and registers the result.
// A new item is taken while a finished result still waits in the output register.
// Reset (synchronous, rst_n low) empties the list and drops any pending result.
`default_nettype none
module array_list_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  ale_in_if.sink    in_ch,
  ale_out_if.source out_ch
);
  import ale_pkg::*;

  state_t                    state_r, state_nxt;
  logic [KIND_W-1:0]         kind_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]          pos_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]        out_index_r, out_index_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                      in_xfer;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]       eq_vec, lt_vec, live_vec;
  logic [IDX_W:0]            hit_eq, hit_ge;

  // Row of cells, each wired to its neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ale_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_r     (cell_data[g]),
      .eq_r       (eq_vec[g]),
      .lt_r       (lt_vec[g])
    );
    assign live_vec[g] = (CNT_W'(g) < count_r);
  end

  // First live match, and first live entry not below the value
  assign hit_eq = first_set(eq_vec & live_vec);
  assign hit_ge = first_set(~lt_vec & live_vec);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;
  assign out_ch.count  = out_count_r;

  // Sequencer: next state, cell control and result
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_status_nxt   = out_status_r;
    out_index_nxt    = out_index_r;
    out_count_nxt    = out_count_r;
    ctrl.op          = OP_HOLD;
    ctrl.tgt         = pos_r[IDX_W-1:0];
    ctrl.value       = value_r;
    ctrl.cmp_en      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = '0;
          case (kind_r)
            KIND_INS_POS: begin
              if (32'(pos_r) > 32'(count_r)) begin
                out_status_nxt = ST_BAD_POS;
              end else if (32'(count_r) >= 32'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op       = OP_SHIFT_UP;
                count_nxt     = count_r + CNT_W'(1);
                out_index_nxt = INDEX_W'(pos_r[IDX_W-1:0]);
              end
            end
            KIND_DELETE: begin
              if (32'(pos_r) >= 32'(count_r)) begin
                out_status_nxt = ST_BAD_POS;
              end else begin
                ctrl.op       = OP_SHIFT_DOWN;
                count_nxt     = count_r - CNT_W'(1);
                out_index_nxt = INDEX_W'(pos_r[IDX_W-1:0]);
              end
            end
            KIND_LOCATE: begin
              if (hit_eq[IDX_W]) begin
                out_status_nxt = ST_NOT_FOUND;
              end else begin
                out_index_nxt = INDEX_W'(hit_eq[IDX_W-1:0]);
              end
            end
            KIND_INS_SORT: begin
              if (32'(count_r) >= 32'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op   = OP_SHIFT_UP;
                count_nxt = count_r + CNT_W'(1);
                // No entry at or above the value: append at the end
                ctrl.tgt  = hit_ge[IDX_W] ? count_r[IDX_W-1:0] : hit_ge[IDX_W-1:0];
                out_index_nxt = INDEX_W'(ctrl.tgt);
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          out_count_nxt = COUNT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_ch.kind;
      value_r <= in_ch.value;
      pos_r   <= in_ch.position;
    end
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
`default_nettype wire

>>> sv/ale_checker.sv
// Port-level assertions for the array list engine, bound to the top level.
`default_nettype none
module ale_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ale_pkg::STATUS_W-1:0]  out_status,
  input wire logic [ale_pkg::INDEX_W-1:0]   out_index,
  input wire logic [ale_pkg::COUNT_W-1:0]   out_count
);
  import ale_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The list never reports more entries than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_count) <= 32'(CAPACITY))
    else $error("count above capacity");

  // A rejected operation reports index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_index == '0)
    else $error("non-zero index on rejected operation");

  // One item in work at a time: no transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a transfer");

endmodule

bind array_list_engine ale_checker u_ale_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.index),
  .out_count  (out_ch.count)
);
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the array list engine: random list traffic checked against a behavioural list.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RANDOM_OPS   = 750;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  // Kinds with no effect on the list
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = ~VAL_MIN;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } list_op_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  // Traffic mixes for the random segments
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} list_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ale_in_if  in_ch ();
  ale_out_if out_ch ();

  array_list_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Behavioural copy of the list
  logic signed [VALUE_W-1:0] list_vals [CAPACITY];
  int unsigned               list_len = 0;

  list_op_t     queued_ops[$];
  list_result_t pending_results[$];
  list_result_t want;

  int unsigned gen_len      = 0;
  int          errors       = 0;
  int          stuck_cycles = 0;
  bit          in_took      = 1'b0;
  int          burst_left   = 1;
  int          gap_left     = 0;
  logic [15:0] rdy_pattern  = '1;
  int          rdy_phase    = 0;

  // Make room at a slot and write the value there
  function automatic void open_list_slot(input int unsigned at,
                                         input logic signed [VALUE_W-1:0] v);
    for (int unsigned i = list_len; i > at; i--) begin
      list_vals[i] = list_vals[i - 1];
    end
    list_vals[at] = v;
    list_len++;
  endfunction

  // Apply one operation to the list and return the result it should give
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t res;
    int unsigned  at;
    int unsigned  slot;
    res.status = ST_OK;
    res.index  = '0;
    at = op.position;
    case (op.kind)
      KIND_INS_POS: begin
        if (at > list_len) begin
          res.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          open_list_slot(at, op.value);
          res.index = INDEX_W'(at);
        end
      end
      KIND_DELETE: begin
        if (at >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          for (int unsigned i = at; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
          end
          list_len--;
          res.index = INDEX_W'(at);
        end
      end
      KIND_LOCATE: begin
        res.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_vals[i] == op.value) begin
            res.status = ST_OK;
            res.index  = INDEX_W'(i);
            break;
          end
        end
      end
      KIND_INS_SORT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < list_len && list_vals[slot] < op.value) slot++;
          open_list_slot(slot, op.value);
          res.index = INDEX_W'(slot);
        end
      end
      KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    if (res.status != ST_OK) res.index = '0;
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  // Length of the list as the generated traffic leaves it, to aim positions
  function automatic void track_len(input list_op_t op);
    case (op.kind)
      KIND_INS_POS:  if (op.position <= gen_len && gen_len < CAPACITY) gen_len++;
      KIND_INS_SORT: if (gen_len < CAPACITY) gen_len++;
      KIND_DELETE:   if (op.position < gen_len) gen_len--;
      KIND_CLEAR:    gen_len = 0;
      default: ;
    endcase
  endfunction

  function automatic void add_op(input logic [KIND_W-1:0] k,
                                 input logic signed [VALUE_W-1:0] v,
                                 input logic [POS_W-1:0] p);
    list_op_t op;
    op.kind     = k;
    op.value    = v;
    op.position = p;
    queued_ops.push_back(op);
    track_len(op);
  endfunction

  // Small values collide often, so locates hit and sorted inserts meet equal entries
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $signed(VALUE_W'($urandom_range(0, 6))) - 32'sd3;
    if (roll < 60) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [KIND_W-1:0] k);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return POS_W'($urandom_range(0, POS_MAX));
    if (roll < 16) return POS_W'(gen_len);
    if (k == KIND_DELETE && gen_len > 0) return POS_W'($urandom_range(0, gen_len - 1));
    return POS_W'($urandom_range(0, gen_len));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input list_mix_t mix);
    int unsigned roll;
    int unsigned ins_top;
    int unsigned sort_top;
    int unsigned loc_top;
    int unsigned del_top;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin ins_top = 35; sort_top = 70; loc_top = 85; del_top = 95; end
      MIX_SHRINK: begin ins_top = 10; sort_top = 20; loc_top = 40; del_top = 95; end
      default:    begin ins_top = 22; sort_top = 45; loc_top = 70; del_top = 95; end
    endcase
    if (roll < ins_top)  return KIND_INS_POS;
    if (roll < sort_top) return KIND_INS_SORT;
    if (roll < loc_top)  return KIND_LOCATE;
    if (roll < del_top)  return KIND_DELETE;
    if (roll < 98)       return KIND_CLEAR;
    return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
  endfunction

  // Sender: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_took || !in_ch.valid) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (queued_ops.size() > 0) begin
        in_ch.kind     <= queued_ops[0].kind;
        in_ch.value    <= queued_ops[0].value;
        in_ch.position <= queued_ops[0].position;
        in_ch.valid    <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern, changed at each wrap
  always @(negedge clk) begin
    if (rdy_phase == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: rdy_pattern = '1;
        3:       rdy_pattern = '0;
        4:       rdy_pattern = 16'h0f0f;
        default: rdy_pattern = 16'($urandom);
      endcase
    end
    out_ch.ready <= rdy_pattern[rdy_phase];
    rdy_phase = (rdy_phase + 1) % 16;
  end

  // Input transfer: predict its result
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_results.push_back(apply_list_op(queued_ops.pop_front()));
      in_took = 1'b1;
    end
  end

  // Result transfer: compare with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d index %0d count %0d",
                 $time, out_ch.status, out_ch.index, out_ch.count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_ch.status);
          errors++;
        end
        if (out_ch.index !== want.index) begin
          $display("%0t: index mismatch: expected %0d actual %0d",
                   $time, want.index, out_ch.index);
          errors++;
        end
        if (out_ch.count !== want.count) begin
          $display("%0t: count mismatch: expected %0d actual %0d",
                   $time, want.count, out_ch.count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with work outstanding but no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (queued_ops.size() == 0 && pending_results.size() == 0)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned         counted;
    int                  seg_left;
    list_mix_t           mix;
    logic [KIND_W-1:0]   k;

    in_ch.valid    = 1'b0;
    in_ch.kind     = '0;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;

    // Directed: empty list, extremes, equal values, misses, spare kinds
    add_op(KIND_CLEAR, 0, 0);
    add_op(KIND_DELETE, 0, 0);
    add_op(KIND_LOCATE, 0, 0);
    add_op(KIND_INS_POS, 1, 1);
    add_op(KIND_INS_POS, VAL_MAX, 0);
    add_op(KIND_INS_POS, VAL_MIN, 0);
    add_op(KIND_INS_POS, 0, 2);
    add_op(KIND_INS_SORT, 0, 0);
    add_op(KIND_INS_SORT, 0, POS_MAX);
    add_op(KIND_LOCATE, 0, 0);
    add_op(KIND_LOCATE, VAL_MAX, 0);
    add_op(KIND_LOCATE, 5, 0);
    add_op(KIND_DELETE, 0, 5);
    add_op(KIND_DELETE, 0, POS_MAX);
    add_op(KIND_SPARE_LO, VAL_MIN, 0);
    add_op(KIND_SPARE_HI, -1, POS_MAX);
    add_op(KIND_DELETE, 0, 4);
    add_op(KIND_INS_SORT, VAL_MIN, 0);
    add_op(KIND_LOCATE, VAL_MIN, 0);
    add_op(KIND_CLEAR, -1, POS_MAX);

    // Fill to capacity, then hit the full list from every side
    repeat (CAPACITY) add_op(KIND_INS_SORT, pick_value(), 0);
    add_op(KIND_INS_POS, 7, CAPACITY + 1);
    add_op(KIND_INS_POS, 7, CAPACITY);
    add_op(KIND_INS_POS, 7, 0);
    add_op(KIND_INS_SORT, VAL_MIN, 0);
    add_op(KIND_DELETE, 0, CAPACITY);
    add_op(KIND_DELETE, 0, CAPACITY - 1);

    // Random segments, each with its own traffic mix
    counted  = 0;
    seg_left = 0;
    mix      = MIX_GROW;
    while (counted < RANDOM_OPS) begin
      if (seg_left == 0) begin
        mix      = list_mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(8, 40);
      end
      k = pick_kind(mix);
      add_op(k, pick_value(), pick_position(k));
      seg_left--;
      if (k <= KIND_CLEAR) counted++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (queued_ops.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
